>>> rtl/rlrf_pkg.sv
package rlrf_pkg;

  localparam int OP_W  = 2;
  localparam int RUN_W = 20;
  localparam int SEC_W = 16;

  localparam int MAX_RANGES_DEF = 256;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  // One stored range.
  typedef struct packed {
    logic [RUN_W-1:0] run;
    logic [SEC_W-1:0] low;
    logic [SEC_W-1:0] high;
  } entry_t;

  // Sequencer controls for the compare unit.
  typedef struct packed {
    logic start;   // clear the match flags
    logic cmp_en;  // fold the current table word into the flags
  } match_ctl_t;

endpackage

>>> rtl/rlrf_in_if.sv
interface rlrf_in_if;
  logic                        valid;
  logic                        ready;
  logic [rlrf_pkg::OP_W-1:0]   operation;
  logic [rlrf_pkg::RUN_W-1:0]  run_number;
  logic [rlrf_pkg::SEC_W-1:0]  range_low;
  logic [rlrf_pkg::SEC_W-1:0]  range_high;
  logic [rlrf_pkg::SEC_W-1:0]  lumi_section;

  modport source (
    output valid, operation, run_number, range_low, range_high, lumi_section,
    input  ready
  );
  modport sink (
    input  valid, operation, run_number, range_low, range_high, lumi_section,
    output ready
  );
endinterface

>>> rtl/rlrf_out_if.sv
interface rlrf_out_if;
  logic valid;
  logic ready;
  logic section_good;
  logic run_known;
  logic table_full;

  modport source (
    output valid, section_good, run_known, table_full,
    input  ready
  );
  modport sink (
    input  valid, section_good, run_known, table_full,
    output ready
  );
endinterface

>>> rtl/rlrf_table.sv
module rlrf_table #(
  parameter int DEPTH = rlrf_pkg::MAX_RANGES_DEF,
  parameter int IDX_W = 8
) (
  input  logic                clk,
  input  logic                we,
  input  logic [IDX_W-1:0]    waddr,
  input  rlrf_pkg::entry_t    wdata,
  input  logic                re,
  input  logic [IDX_W-1:0]    raddr,
  output rlrf_pkg::entry_t    rdata
);

  rlrf_pkg::entry_t mem [DEPTH];
  rlrf_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/rlrf_match.sv
module rlrf_match (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rlrf_pkg::match_ctl_t          ctl,
  input  rlrf_pkg::entry_t              entry,
  input  logic [rlrf_pkg::RUN_W-1:0]    run,
  input  logic [rlrf_pkg::SEC_W-1:0]    sec,
  output logic                          known,
  output logic                          good
);

  logic known_r, known_nxt;
  logic good_r, good_nxt;
  logic run_hit;
  logic sec_hit;

  assign run_hit = (entry.run == run);
  assign sec_hit = (entry.low <= sec) && (sec <= entry.high);

  always_comb begin
    known_nxt = known_r;
    good_nxt  = good_r;
    if (ctl.start) begin
      known_nxt = 1'b0;
      good_nxt  = 1'b0;
    end else if (ctl.cmp_en && run_hit) begin
      known_nxt = 1'b1;
      good_nxt  = good_r | sec_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      known_r <= 1'b0;
      good_r  <= 1'b0;
    end else begin
      known_r <= known_nxt;
      good_r  <= good_nxt;
    end
  end

  assign known = known_r;
  assign good  = good_r;

endmodule

>>> rtl/run_lumi_range_filter.sv
// Channel   Dir  Beat payload
// in_ch     in   operation, run_number, range_low, range_high, lumi_section
// out_ch    out  section_good, run_known, table_full
// cfg       in   cfg_we / cfg_wdata -> bypass_all_good
//
// Insert, clear, the unused code and a query on an empty table: idle, then done.
// Query: idle, scan, drain, done; one stored entry is read from the table memory
// and checked by the shared compare unit per cycle, so the table walk sets the rate.
// Reset (rst_n low, synchronous) empties the table; stored words keep old data.
// in_ch.ready is high only in the idle state. A finished result waits in the output
// register; the block takes the next beat meanwhile and stalls only at its own end.
module run_lumi_range_filter #(
  parameter int MAX_RANGES = rlrf_pkg::MAX_RANGES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  rlrf_in_if.sink     in_ch,
  rlrf_out_if.source  out_ch
);

  localparam int IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int CNT_W = $clog2(MAX_RANGES + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state_r, state_nxt;

  // Configuration.
  logic bypass_r;

  // Latched item.
  logic [rlrf_pkg::OP_W-1:0]  op_r;
  logic [rlrf_pkg::RUN_W-1:0] run_r;
  logic [rlrf_pkg::SEC_W-1:0] sec_r;
  logic                       full_r;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             rd_vld_r;

  // Output register.
  logic out_valid_r, out_valid_nxt;
  logic out_good_r;
  logic out_known_r;
  logic out_full_r;

  logic             accept;
  logic             is_full;
  logic             tbl_we;
  logic             tbl_re;
  logic             scan_last;
  logic             out_free;
  logic             load_out;
  rlrf_pkg::entry_t wr_entry;
  rlrf_pkg::entry_t rd_entry;
  rlrf_pkg::match_ctl_t mctl;
  logic             m_known;
  logic             m_good;

  assign accept    = in_ch.valid && in_ch.ready;
  assign is_full   = (count_r == CNT_W'(MAX_RANGES));
  assign tbl_we    = accept && (in_ch.operation == rlrf_pkg::OP_INSERT) && !is_full;
  assign tbl_re    = (state_r == S_SCAN);
  assign scan_last = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);
  assign out_free  = !out_valid_r || out_ch.ready;
  assign load_out  = (state_r == S_DONE) && out_free;

  assign in_ch.ready = (state_r == S_IDLE);

  assign wr_entry.run  = in_ch.run_number;
  assign wr_entry.low  = in_ch.range_low;
  assign wr_entry.high = in_ch.range_high;

  assign mctl.start  = accept;
  assign mctl.cmp_en = rd_vld_r;

  rlrf_table #(
    .DEPTH (MAX_RANGES),
    .IDX_W (IDX_W)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (wr_entry),
    .re    (tbl_re),
    .raddr (idx_r),
    .rdata (rd_entry)
  );

  rlrf_match u_match (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mctl),
    .entry (rd_entry),
    .run   (run_r),
    .sec   (sec_r),
    .known (m_known),
    .good  (m_good)
  );

  // Sequencer: idle -> (scan -> drain ->) done -> idle.
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    count_nxt = count_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          idx_nxt = '0;
          if (in_ch.operation == rlrf_pkg::OP_INSERT) begin
            if (!is_full) begin
              count_nxt = count_r + CNT_W'(1);
            end
            state_nxt = S_DONE;
          end else if (in_ch.operation == rlrf_pkg::OP_CLEAR) begin
            count_nxt = '0;
            state_nxt = S_DONE;
          end else if (in_ch.operation == rlrf_pkg::OP_QUERY && count_r != '0) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_SCAN: begin
        // Advance one entry per cycle; the last read drains next cycle.
        idx_nxt = idx_r + IDX_W'(1);
        if (scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // Hold until the output register can take the result.
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      bypass_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      rd_vld_r    <= tbl_re;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        bypass_r <= cfg_wdata;
      end
    end
  end

  // Item capture; payload only.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_ch.operation;
      run_r  <= in_ch.run_number;
      sec_r  <= in_ch.lumi_section;
      full_r <= is_full;
    end
  end

  // Result formatting: fields that do not apply to the operation stay 0.
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_good_r  <= (op_r == rlrf_pkg::OP_QUERY) && (m_good || bypass_r);
      out_known_r <= (op_r == rlrf_pkg::OP_QUERY) && m_known;
      out_full_r  <= (op_r == rlrf_pkg::OP_INSERT) && full_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.section_good = out_good_r;
  assign out_ch.run_known    = out_known_r;
  assign out_ch.table_full   = out_full_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_RANGES))
    else $error("entry count beyond table depth");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.operation == rlrf_pkg::OP_INSERT && is_full) |=> $stable(count_r))
    else $error("insert into full table changed the count");

  a_good_known: assert property (@(posedge clk) disable iff (!rst_n)
    m_good |-> m_known)
    else $error("range hit without run hit");

  a_read_follows_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> ($past(state_r) == S_SCAN))
    else $error("compare without a table read");
`endif

endmodule
